[design/double_ended_priority_queue_top_defines.svh]
// Assertion macros for the double-ended priority queue design.
// No dependencies; included by the top level for its concurrent checks.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[design/dpq_pkg.sv]
// Types and constants for the double-ended priority queue.
// No dependencies; imported by the top level.
package dpq_pkg;

   localparam int DATA_W     = 32;
   localparam int OPCODE_W   = 2;
   localparam int COUNT_O_W  = 7;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT     = 2'd0,
      OP_REMOVE_MAX = 2'd1,
      OP_REMOVE_MIN = 2'd2,
      OP_CLEAR      = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_INS_READ,
      ST_INS_CMP,
      ST_INS_WRITE,
      ST_REPORT,
      ST_RPT_MIN,
      ST_RPT_MAX,
      ST_DONE
   } state_type;

endpackage

[design/dpq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; instanced by the priority queue top level.
module dpq_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/double_ended_priority_queue_top.sv]
// Double-ended priority queue: a sequencer around one RAM and one address adder.
// Depends on dpq_pkg, dpq_ram and double_ended_priority_queue_top_defines.svh.
//
// The queue holds up to CAPACITY signed 32-bit values in ascending order in a
// circular RAM, so removing the minimum only advances a base pointer and
// removing the maximum only drops the count. One operation is taken at a time:
// req_stall stays high from the transfer until the result is loaded into the
// output register. A remove or clear goes from the execute state to the report
// states, reading the minimum and maximum unless the queue ends up empty. An
// insert compares the new value against stored entries (at most the entry
// count before the insert); each compare costs a RAM read and a
// compare-and-shift step. An insert into a full queue is refused and reports
// dropped. Every operation returns exactly one result with maximum, minimum,
// count and an empty flag; the result register lets the next operation start
// while it waits.
`include "double_ended_priority_queue_top_defines.svh"

module double_ended_priority_queue_top #(
   parameter int CAPACITY = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [dpq_pkg::OPCODE_W-1:0]          req_opcode,
   input  logic signed [dpq_pkg::DATA_W-1:0]     req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [dpq_pkg::DATA_W-1:0]     rsp_max_value,
   output logic signed [dpq_pkg::DATA_W-1:0]     rsp_min_value,
   output logic                                  rsp_is_empty,
   output logic [dpq_pkg::COUNT_O_W-1:0]         rsp_entry_count,
   output logic                                  rsp_dropped
);

   import dpq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = AW + 1;
   localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);
   localparam logic [SW-1:0] CAP_SUM_C = SW'(CAPACITY);

   // Control state.
   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     base_ff, base_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Work and output payload.
   opcode_type        op_ff, op_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic [AW-1:0]     pos_ff, pos_in;
   logic              drop_ff, drop_in;
   logic signed [DATA_W-1:0] wmin_ff, wmin_in;
   logic signed [DATA_W-1:0] wmax_ff, wmax_in;
   logic signed [DATA_W-1:0] omax_ff, omax_in;
   logic signed [DATA_W-1:0] omin_ff, omin_in;
   logic              oempty_ff, oempty_in;
   logic [COUNT_O_W-1:0] ocount_ff, ocount_in;
   logic              odrop_ff, odrop_in;

   // Shared address unit: physical slot of a logical offset from the base.
   logic [AW-1:0]     offset;
   logic [SW-1:0]     addr_sum;
   logic [AW-1:0]     phys_addr;

   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data, rd_data;

   always_comb begin
      unique case (state_ff)
         ST_EXEC:                 offset = AW'(1);
         ST_INS_READ:             offset = pos_ff - AW'(1);
         ST_INS_CMP, ST_INS_WRITE: offset = pos_ff;
         ST_RPT_MIN:              offset = AW'(count_ff - CW'(1));
         default:                 offset = '0;
      endcase
      addr_sum = SW'(base_ff) + SW'(offset);
      if (addr_sum >= CAP_SUM_C) begin
         addr_sum = addr_sum - CAP_SUM_C;
      end
      phys_addr = addr_sum[AW-1:0];
   end

   dpq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY),
      .ADDR_W(AW)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      base_in      = base_ff;
      op_in        = op_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      drop_in      = drop_ff;
      wmin_in      = wmin_ff;
      wmax_in      = wmax_ff;
      omax_in      = omax_ff;
      omin_in      = omin_ff;
      oempty_in    = oempty_ff;
      ocount_in    = ocount_ff;
      odrop_in     = odrop_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = phys_addr;
      wr_data      = val_ff;
      rd_en        = 1'b0;
      rd_addr      = phys_addr;
      req_stall    = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in    = opcode_type'(req_opcode);
               val_in   = req_value;
               drop_in  = 1'b0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_REPORT;
            unique case (op_ff)
               OP_INSERT: begin
                  if (count_ff == CAP_C) begin
                     drop_in = 1'b1;
                  end else begin
                     pos_in   = AW'(count_ff);
                     state_in = (count_ff == '0) ? ST_INS_WRITE : ST_INS_READ;
                  end
               end
               OP_REMOVE_MAX: begin
                  if (count_ff != '0) begin
                     count_in = count_ff - CW'(1);
                  end
               end
               OP_REMOVE_MIN: begin
                  if (count_ff != '0) begin
                     count_in = count_ff - CW'(1);
                     base_in  = phys_addr;
                  end
               end
               OP_CLEAR: begin
                  count_in = '0;
               end
            endcase
         end
         ST_INS_READ: begin
            rd_en    = 1'b1;
            state_in = ST_INS_CMP;
         end
         ST_INS_CMP: begin
            // Larger entries move up one slot; an equal entry stays below.
            if ($signed(rd_data) > val_ff) begin
               wr_en    = 1'b1;
               wr_data  = rd_data;
               pos_in   = pos_ff - AW'(1);
               state_in = (pos_ff == AW'(1)) ? ST_INS_WRITE : ST_INS_READ;
            end else begin
               state_in = ST_INS_WRITE;
            end
         end
         ST_INS_WRITE: begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (count_ff == '0) begin
               wmin_in  = '0;
               wmax_in  = '0;
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_RPT_MIN;
            end
         end
         ST_RPT_MIN: begin
            wmin_in  = rd_data;
            rd_en    = 1'b1;
            state_in = ST_RPT_MAX;
         end
         ST_RPT_MAX: begin
            wmax_in  = rd_data;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               omax_in      = wmax_ff;
               omin_in      = wmin_ff;
               oempty_in    = (count_ff == '0);
               ocount_in    = COUNT_O_W'(count_ff);
               odrop_in     = drop_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      val_ff    <= val_in;
      pos_ff    <= pos_in;
      drop_ff   <= drop_in;
      wmin_ff   <= wmin_in;
      wmax_ff   <= wmax_in;
      omax_ff   <= omax_in;
      omin_ff   <= omin_in;
      oempty_ff <= oempty_in;
      ocount_ff <= ocount_in;
      odrop_ff  <= odrop_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_max_value   = omax_ff;
   assign rsp_min_value   = omin_ff;
   assign rsp_is_empty    = oempty_ff;
   assign rsp_entry_count = ocount_ff;
   assign rsp_dropped     = odrop_ff;

   `DPQ_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CAP_C)
   `DPQ_ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_valid && !req_stall, state_ff != ST_IDLE)
   `DPQ_ASSERT_SAME(a_empty_reports_zero, clock, reset, rsp_valid && rsp_is_empty, rsp_max_value == '0 && rsp_min_value == '0)
   `DPQ_ASSERT_SAME(a_min_below_max, clock, reset, rsp_valid && !rsp_is_empty, rsp_min_value <= rsp_max_value)

endmodule

[sim/double_ended_priority_queue_top_tb.sv]
// Self-checking testbench for double_ended_priority_queue_top: random and directed
// operations with random idle and back-pressure on both channels, checked by a scoreboard.
// Depends on dpq_pkg and the design files of the double-ended priority queue.
module double_ended_priority_queue_top_tb;
   import dpq_pkg::*;

   localparam int QUEUE_DEPTH   = 64;
   localparam int RANDOM_ITEMS  = 950;
   localparam int DRAIN_CYCLES  = 2 * QUEUE_DEPTH + 40;
   localparam int CYCLE_LIMIT   = 1_000_000;

   localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] MOST_POSITIVE = 32'sh7FFF_FFFF;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} op_mix_type;

   typedef struct {
      logic signed [DATA_W-1:0] max_value;
      logic signed [DATA_W-1:0] min_value;
      logic                     is_empty;
      logic [COUNT_O_W-1:0]     entry_count;
      logic                     dropped;
   } report_type;

   class dpq_scoreboard;
      logic signed [DATA_W-1:0] sorted_contents[$];
      report_type               pending_reports[$];
      int unsigned              mismatches;

      function new();
         mismatches = 0;
      endfunction

      // Updates the ascending copy of the queue and queues the report it implies.
      function void note_operation(opcode_type op, logic signed [DATA_W-1:0] val);
         report_type rpt;
         int         pos;
         rpt.dropped = 1'b0;
         case (op)
            OP_INSERT: begin
               if (sorted_contents.size() >= QUEUE_DEPTH) begin
                  rpt.dropped = 1'b1;
               end else begin
                  // A new value lands above any equal entries.
                  pos = sorted_contents.size();
                  while (pos > 0 && sorted_contents[pos-1] > val) pos--;
                  sorted_contents.insert(pos, val);
               end
            end
            OP_REMOVE_MAX: begin
               if (sorted_contents.size() > 0) void'(sorted_contents.pop_back());
            end
            OP_REMOVE_MIN: begin
               if (sorted_contents.size() > 0) void'(sorted_contents.pop_front());
            end
            default: begin
               sorted_contents.delete();
            end
         endcase
         if (sorted_contents.size() == 0) begin
            rpt.max_value = '0;
            rpt.min_value = '0;
            rpt.is_empty  = 1'b1;
         end else begin
            rpt.max_value = sorted_contents[sorted_contents.size()-1];
            rpt.min_value = sorted_contents[0];
            rpt.is_empty  = 1'b0;
         end
         rpt.entry_count = COUNT_O_W'(sorted_contents.size());
         pending_reports.push_back(rpt);
      endfunction

      function void check_report(report_type got);
         report_type want;
         if (pending_reports.size() == 0) begin
            $error("result transfer with no expected result pending");
            mismatches++;
            return;
         end
         want = pending_reports.pop_front();
         if (got.max_value !== want.max_value) begin
            $error("rsp_max_value: expected %0d, actual %0d", want.max_value, got.max_value);
            mismatches++;
         end
         if (got.min_value !== want.min_value) begin
            $error("rsp_min_value: expected %0d, actual %0d", want.min_value, got.min_value);
            mismatches++;
         end
         if (got.is_empty !== want.is_empty) begin
            $error("rsp_is_empty: expected %0d, actual %0d", want.is_empty, got.is_empty);
            mismatches++;
         end
         if (got.entry_count !== want.entry_count) begin
            $error("rsp_entry_count: expected %0d, actual %0d",
                   want.entry_count, got.entry_count);
            mismatches++;
         end
         if (got.dropped !== want.dropped) begin
            $error("rsp_dropped: expected %0d, actual %0d", want.dropped, got.dropped);
            mismatches++;
         end
      endfunction

      function bit all_clear();
         if (pending_reports.size() != 0) begin
            $error("%0d expected results never arrived", pending_reports.size());
         end
         return (mismatches == 0) && (pending_reports.size() == 0);
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [OPCODE_W-1:0]         req_opcode = OP_INSERT;
   logic signed [DATA_W-1:0]    req_value = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [DATA_W-1:0]    rsp_max_value;
   logic signed [DATA_W-1:0]    rsp_min_value;
   logic                        rsp_is_empty;
   logic [COUNT_O_W-1:0]        rsp_entry_count;
   logic                        rsp_dropped;

   dpq_scoreboard board = new();
   int unsigned   cycle_count = 0;

   double_ended_priority_queue_top #(.CAPACITY(QUEUE_DEPTH)) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_max_value   (rsp_max_value),
      .rsp_min_value   (rsp_min_value),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_entry_count (rsp_entry_count),
      .rsp_dropped     (rsp_dropped)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Both channels are observed at the rising edge, before the design updates.
   always @(posedge clock) begin
      report_type got;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            board.note_operation(opcode_type'(req_opcode), req_value);
         end
         if (rsp_valid && !rsp_stall) begin
            got.max_value   = rsp_max_value;
            got.min_value   = rsp_min_value;
            got.is_empty    = rsp_is_empty;
            got.entry_count = rsp_entry_count;
            got.dropped     = rsp_dropped;
            board.check_report(got);
         end
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return $urandom;
      // A narrow range produces plenty of duplicates.
      if (r < 8) return $urandom_range(0, 16) - 8;
      case ($urandom_range(0, 5))
         0:       return MOST_NEGATIVE;
         1:       return MOST_NEGATIVE + 1;
         2:       return MOST_POSITIVE;
         3:       return MOST_POSITIVE - 1;
         4:       return -1;
         default: return 0;
      endcase
   endfunction

   function automatic opcode_type pick_opcode(op_mix_type mix);
      int r;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_FILL: begin
            if (r < 88) return OP_INSERT;
            if (r < 94) return OP_REMOVE_MAX;
            return OP_REMOVE_MIN;
         end
         MIX_DRAIN: begin
            if (r < 15) return OP_INSERT;
            if (r < 55) return OP_REMOVE_MAX;
            if (r < 96) return OP_REMOVE_MIN;
            return OP_CLEAR;
         end
         default: begin
            if (r < 48) return OP_INSERT;
            if (r < 73) return OP_REMOVE_MAX;
            if (r < 98) return OP_REMOVE_MIN;
            return OP_CLEAR;
         end
      endcase
   endfunction

   // Presents one operation and returns at the edge where it is transferred.
   task automatic send_op(opcode_type op, logic signed [DATA_W-1:0] val, bit calm);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_value  <= val;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic run_directed();
      send_op(OP_REMOVE_MAX, 32'sh5A5A_5A5A, 1'b0);
      send_op(OP_REMOVE_MIN, -1, 1'b0);
      send_op(OP_CLEAR, MOST_NEGATIVE, 1'b0);
      send_op(OP_INSERT, MOST_POSITIVE, 1'b0);
      send_op(OP_INSERT, MOST_NEGATIVE, 1'b0);
      send_op(OP_INSERT, 0, 1'b0);
      send_op(OP_INSERT, 0, 1'b0);
      send_op(OP_INSERT, -1, 1'b0);
      send_op(OP_INSERT, 1, 1'b0);
      send_op(OP_REMOVE_MAX, 0, 1'b0);
      send_op(OP_REMOVE_MIN, MOST_POSITIVE, 1'b0);
      send_op(OP_REMOVE_MIN, 0, 1'b0);
      send_op(OP_INSERT, 5, 1'b0);
      send_op(OP_INSERT, 5, 1'b0);
      send_op(OP_INSERT, 5, 1'b0);
      send_op(OP_REMOVE_MAX, 0, 1'b0);
      send_op(OP_REMOVE_MAX, 0, 1'b0);
      send_op(OP_CLEAR, 0, 1'b0);
      send_op(OP_INSERT, -7, 1'b0);
      send_op(OP_REMOVE_MIN, 0, 1'b0);
      send_op(OP_REMOVE_MAX, 0, 1'b0);
      send_op(OP_INSERT, MOST_POSITIVE - 1, 1'b1);
      send_op(OP_INSERT, MOST_NEGATIVE + 1, 1'b1);
      send_op(OP_REMOVE_MIN, 0, 1'b1);
   endtask

   // Bursts of one operation mix; the first burst is mostly inserts and is longer than the capacity.
   task automatic run_random();
      op_mix_type mix;
      int         burst_len;
      int         sent;
      bit         calm;
      bit         first_burst;
      sent = 0;
      first_burst = 1'b1;
      while (sent < RANDOM_ITEMS) begin
         mix       = first_burst ? MIX_FILL : op_mix_type'($urandom_range(0, 2));
         burst_len = first_burst ? QUEUE_DEPTH + 20 : $urandom_range(20, 80);
         calm      = ($urandom_range(0, 4) == 0);
         first_burst = 1'b0;
         repeat (burst_len) begin
            send_op(pick_opcode(mix), pick_value(), calm);
            sent++;
         end
      end
   endtask

   initial begin
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(50, 200)) @(negedge clock);
         end else begin
            int hold;
            hold = pick_gap();
            rsp_stall <= (hold != 0);
            repeat ((hold == 0) ? 1 : hold) @(negedge clock);
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.all_clear()) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
